>>> hw/rtl/lz4d_pkg.sv
// lz4 block decoder package: item types, phase codes, error codes and constants
package lz4d_pkg;

  localparam int unsigned HistDepth  = 65536;
  localparam int unsigned HistAw     = $clog2(HistDepth);
  localparam int unsigned BurstLimit = 64;
  localparam int unsigned BurstW     = $clog2(BurstLimit + 1);
  localparam int unsigned LenW       = 24;

  localparam logic [3:0]      NibExt   = 4'd15;
  localparam logic [7:0]      ByteExt  = 8'd255;
  localparam logic [LenW-1:0] LenSat   = {LenW{1'b1}};
  localparam logic [LenW-1:0] MinMatch = LenW'(4);
  localparam logic [LenW-1:0] MaxBlockReset = LenW'(8388608);

  // func codes
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_CONT = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LIMIT = 2'd1;
  localparam logic [1:0] ERR_OFF   = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  // parse phases
  localparam logic [2:0] PH_TOKEN    = 3'd0;
  localparam logic [2:0] PH_LITLEN   = 3'd1;
  localparam logic [2:0] PH_LITERALS = 3'd2;
  localparam logic [2:0] PH_OFF_LO   = 3'd3;
  localparam logic [2:0] PH_OFF_HI   = 3'd4;
  localparam logic [2:0] PH_MATLEN   = 3'd5;
  localparam logic [2:0] PH_COPY     = 3'd6;
  localparam logic [2:0] PH_DRAIN    = 3'd7;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic       block_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       more_pending;
    logic       end_of_block;
    logic [1:0] error_code;
  } out_item_t;

  // command from the parser to the back end
  typedef struct packed {
    logic            is_copy;   // 1: copy a burst from history, 0: single result
    out_item_t       res;       // single result (literal, end or error)
    logic            wr_hist;   // literal byte to write into history
    logic [HistAw-1:0] wr_addr;
    logic [HistAw-1:0] src_addr; // first copy source
    logic [HistAw-1:0] dst_addr; // first copy destination
    logic [BurstW-1:0] count;    // bytes in this burst
    logic            more;       // match bytes remain after the burst
  } cmd_t;

endpackage

>>> hw/rtl/lz4d_front.sv
// lz4 parser: accepts items, tracks block state, issues commands to the back end
module lz4d_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [23:0]             cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  lz4d_pkg::in_item_t      in_item,
  output logic                    cmd_push,
  output lz4d_pkg::cmd_t          cmd,
  input  logic                    cmd_full
);
  import lz4d_pkg::*;

  logic [LenW-1:0] max_r;
  logic [LenW-1:0] cnt_r, cnt_nxt;
  logic [2:0]      ph_r, ph_nxt;
  logic [LenW-1:0] lit_r, lit_nxt;
  logic [LenW-1:0] mat_r, mat_nxt;
  logic [15:0]     dist_r, dist_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic            err_r, err_nxt;

  logic            acc;
  logic [7:0]      c;
  logic            last;
  logic [LenW:0]   add_len;
  logic            over;
  logic [LenW:0]   sat_sum;
  logic [LenW-1:0] sat_res;
  logic [LenW-1:0] burst_n;
  logic            new_blk;

  assign in_stall = cmd_full;
  assign acc = in_valid && !in_stall;
  assign c = in_item.in_byte;
  assign last = in_item.block_last;

  // saturating length add for extension bytes
  always_comb begin
    if (ph_r == PH_LITLEN) sat_sum = {1'b0, lit_r} + (LenW+1)'(c);
    else                   sat_sum = {1'b0, mat_r} + (LenW+1)'(c);
    sat_res = sat_sum[LenW] ? LenSat : sat_sum[LenW-1:0];
  end

  // block parser
  always_comb begin
    cnt_nxt = cnt_r; ph_nxt = ph_r; lit_nxt = lit_r; mat_nxt = mat_r;
    dist_nxt = dist_r; nib_nxt = nib_r; err_nxt = err_r;
    cmd = '0; cmd_push = 1'b0; new_blk = 1'b0;
    add_len = '0; over = 1'b0; burst_n = '0;
    if (acc) begin
      if (ph_r == PH_COPY) begin
        // continue the pending match
        burst_n = (mat_r > LenW'(BurstLimit)) ? LenW'(BurstLimit) : mat_r;
        cmd_push = 1'b1; cmd.is_copy = 1'b1;
        cmd.count = BurstW'(burst_n);
        cmd.src_addr = HistAw'(cnt_r - LenW'(dist_r));
        cmd.dst_addr = HistAw'(cnt_r);
        cmd.more = (mat_r != burst_n);
        mat_nxt = mat_r - burst_n;
        cnt_nxt = cnt_r + burst_n;
        ph_nxt = cmd.more ? PH_COPY : PH_TOKEN;
      end else if (in_item.func == FUNC_DATA) begin
        case (ph_r)
          PH_DRAIN: begin
            if (last) new_blk = 1'b1;
          end
          PH_TOKEN: begin
            nib_nxt = c[3:0];
            if (c[7:4] == NibExt) begin
              lit_nxt = LenW'(NibExt); ph_nxt = PH_LITLEN;
              if (last) begin
                cmd_push = 1'b1; cmd.res.error_code = ERR_TRUNC;
              end
            end else if (c[7:4] != 4'd0) begin
              add_len = {1'b0, cnt_r} + (LenW+1)'(c[7:4]);
              over = add_len > (LenW+1)'(max_r);
              lit_nxt = LenW'(c[7:4]); ph_nxt = PH_LITERALS;
              if (over || last) begin
                cmd_push = 1'b1; cmd.res.error_code = over ? ERR_LIMIT : ERR_TRUNC;
              end
            end else if (last) begin
              cmd_push = 1'b1; cmd.res.end_of_block = 1'b1; new_blk = 1'b1;
            end else begin
              ph_nxt = PH_OFF_LO;
            end
          end
          PH_LITLEN: begin
            lit_nxt = sat_res;
            add_len = {1'b0, cnt_r} + {1'b0, sat_res};
            over = (c != ByteExt) && (add_len > (LenW+1)'(max_r));
            if (c != ByteExt) ph_nxt = PH_LITERALS;
            if (over || last) begin
              cmd_push = 1'b1; cmd.res.error_code = over ? ERR_LIMIT : ERR_TRUNC;
            end
          end
          PH_LITERALS: begin
            cmd_push = 1'b1;
            if (last && lit_r != LenW'(1)) begin
              cmd.res.error_code = ERR_TRUNC;
            end else begin
              cmd.wr_hist = 1'b1; cmd.wr_addr = HistAw'(cnt_r);
              cmd.res.out_byte = c; cmd.res.has_byte = 1'b1;
              cnt_nxt = cnt_r + LenW'(1);
              if (lit_r != '0) lit_nxt = lit_r - LenW'(1);
              if (last) begin
                cmd.res.end_of_block = 1'b1; new_blk = 1'b1;
              end else if (lit_r <= LenW'(1)) begin
                ph_nxt = PH_OFF_LO;
              end
            end
          end
          PH_OFF_LO: begin
            dist_nxt = {8'd0, c};
            if (last) begin
              cmd_push = 1'b1; cmd.res.error_code = ERR_TRUNC;
            end else begin
              ph_nxt = PH_OFF_HI;
            end
          end
          PH_OFF_HI: begin
            dist_nxt = {c, dist_r[7:0]};
            if (dist_nxt == 16'd0 || LenW'(dist_nxt) > cnt_r
                || 32'(dist_nxt) > 32'(HistDepth)) begin
              cmd_push = 1'b1; cmd.res.error_code = ERR_OFF;
            end else if (nib_r == NibExt) begin
              mat_nxt = LenW'(NibExt) + MinMatch; ph_nxt = PH_MATLEN;
              if (last) begin
                cmd_push = 1'b1; cmd.res.error_code = ERR_TRUNC;
              end
            end else begin
              mat_nxt = LenW'(nib_r) + MinMatch;
            end
          end
          PH_MATLEN: begin
            mat_nxt = sat_res;
            if (c == ByteExt && last) begin
              cmd_push = 1'b1; cmd.res.error_code = ERR_TRUNC;
            end
          end
          default: ;
        endcase
        // start a match once its length is known
        if (!cmd_push && ((ph_r == PH_OFF_HI && nib_r != NibExt)
            || (ph_r == PH_MATLEN && c != ByteExt))) begin
          add_len = {1'b0, cnt_r} + {1'b0, mat_nxt};
          cmd_push = 1'b1;
          if (add_len > (LenW+1)'(max_r)) begin
            cmd.res.error_code = ERR_LIMIT;
          end else if (last) begin
            cmd.res.error_code = ERR_TRUNC;
          end else begin
            burst_n = (mat_nxt > LenW'(BurstLimit)) ? LenW'(BurstLimit) : mat_nxt;
            cmd.is_copy = 1'b1;
            cmd.count = BurstW'(burst_n);
            cmd.src_addr = HistAw'(cnt_r - LenW'(dist_nxt));
            cmd.dst_addr = HistAw'(cnt_r);
            cmd.more = (mat_nxt != burst_n);
            mat_nxt = mat_nxt - burst_n;
            cnt_nxt = cnt_r + burst_n;
            ph_nxt = cmd.more ? PH_COPY : PH_TOKEN;
          end
        end
        // error handling: restart on last, else drain
        if (cmd_push && !cmd.is_copy && cmd.res.error_code != ERR_NONE) begin
          if (last || cmd.res.error_code == ERR_TRUNC) begin
            new_blk = 1'b1;
          end else begin
            ph_nxt = PH_DRAIN; err_nxt = 1'b1;
          end
        end
      end
      if (cmd_push && !cmd.is_copy) cmd.res.last_of_run = 1'b1;
      if (new_blk) begin
        cnt_nxt = '0; ph_nxt = PH_TOKEN; lit_nxt = '0; mat_nxt = '0;
        dist_nxt = '0; nib_nxt = '0; err_nxt = 1'b0;
      end
    end
  end

  // block state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MaxBlockReset;
      cnt_r <= '0; ph_r <= PH_TOKEN; lit_r <= '0; mat_r <= '0;
      dist_r <= '0; nib_r <= '0; err_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      cnt_r <= cnt_nxt; ph_r <= ph_nxt; lit_r <= lit_nxt; mat_r <= mat_nxt;
      dist_r <= dist_nxt; nib_r <= nib_nxt; err_r <= err_nxt;
    end
  end

  // drain state goes with the latched error flag
  assert property (@(posedge clk) disable iff (!rst_n) (ph_r == PH_DRAIN) |-> err_r)
    else $error("drain without latched error");
  // copy phase always has bytes left
  assert property (@(posedge clk) disable iff (!rst_n) (ph_r == PH_COPY) |-> (mat_r != '0))
    else $error("copy phase with empty match");
  // no command while the queue is full
  assert property (@(posedge clk) disable iff (!rst_n) cmd_full |-> !cmd_push)
    else $error("push into full queue");

endmodule

>>> hw/rtl/lz4d_queue.sv
// two-entry command queue between parser and back end
module lz4d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lz4d_pkg::cmd_t  din,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output lz4d_pkg::cmd_t  dout
);
  import lz4d_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign dout = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");

endmodule

>>> hw/rtl/lz4d_back.sv
// back end: history store, byte copy engine and result register
module lz4d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_avail,
  input  lz4d_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lz4d_pkg::out_item_t out_item
);
  import lz4d_pkg::*;

  logic [7:0] hist_mem [HistDepth];

  // copy engine: read issue stage then write/emit stage
  logic              busy_r;
  logic [HistAw-1:0] src_r, dst_r;
  logic [BurstW-1:0] left_r;
  logic              more_r;
  logic              rd_v_r;       // read data is valid in rd_data_r
  logic              rd_last_r;
  logic              rd_more_r;
  logic [HistAw-1:0] rd_dst_r;
  logic [7:0]        rd_data_r;

  logic              ov_r;
  out_item_t         oi_r;

  logic out_free;
  logic issue;
  logic [7:0] cp_byte;
  logic single;

  // output register free when empty or being taken
  assign out_free = !ov_r || !out_stall;
  // a read issued in flight must find room, so only issue when output is free now
  // and no other read is pending
  assign issue = busy_r && !rd_v_r && out_free;
  assign single = cmd_avail && !busy_r && !rd_v_r && !cmd.is_copy && out_free;
  assign cmd_pop = single || (cmd_avail && !busy_r && !rd_v_r && cmd.is_copy);
  assign out_valid = ov_r;
  assign out_item = oi_r;

  // a copied byte is written back before the next read issues, so overlap works
  assign cp_byte = rd_data_r;

  // history memory: literal writes, copy writes, copy reads
  always_ff @(posedge clk) begin
    if (single && cmd.wr_hist) hist_mem[cmd.wr_addr] <= cmd.res.out_byte;
    else if (rd_v_r && out_free) hist_mem[rd_dst_r] <= cp_byte;
    if (issue) rd_data_r <= hist_mem[src_r];
  end

  // copy sequencing and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; rd_v_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (out_free) ov_r <= 1'b0;
      if (cmd_pop && cmd.is_copy) begin
        busy_r <= 1'b1; src_r <= cmd.src_addr; dst_r <= cmd.dst_addr;
        left_r <= cmd.count; more_r <= cmd.more;
      end
      if (issue) begin
        rd_v_r <= 1'b1; rd_dst_r <= dst_r;
        rd_last_r <= (left_r == BurstW'(1)); rd_more_r <= more_r;
        src_r <= src_r + HistAw'(1); dst_r <= dst_r + HistAw'(1);
        left_r <= left_r - BurstW'(1);
        if (left_r == BurstW'(1)) busy_r <= 1'b0;
      end
      if (rd_v_r && out_free) begin
        rd_v_r <= 1'b0; ov_r <= 1'b1;
        oi_r <= '{out_byte: cp_byte, has_byte: 1'b1, last_of_run: rd_last_r,
                  more_pending: rd_last_r && rd_more_r, end_of_block: 1'b0,
                  error_code: ERR_NONE};
      end else if (single) begin
        ov_r <= 1'b1; oi_r <= cmd.res;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(single && rd_v_r))
    else $error("single result during copy read");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !(cmd_pop))
    else $error("command taken while copy busy");
  assert property (@(posedge clk) disable iff (!rst_n) issue |=> rd_v_r)
    else $error("issued read lost");

endmodule

>>> hw/rtl/lz4_block_decoder.sv
// lz4 block decoder top level: parser, command queue and copy back end
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_item (func, in_byte, block_last)
//  out     | output    | out_valid / out_stall | out_item (byte, flags, error_code)
//  cfg     | input     | cfg_we                | cfg_wdata (max_block_bytes)
//
// a literal or error result passes from the queue straight into the result register.
// match bytes leave one at a time (history read, then write and emit), up to 64
// per item; the parser moves on while the back end copies, until the queue fills.
// reset is synchronous and clears all control state; the history store is not cleared.
// out_stall holds the result register and, through the queue, stalls input.
module lz4_block_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  lz4d_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lz4d_pkg::out_item_t out_item
);
  import lz4d_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, avail, pop;

  lz4d_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_item,
    .cmd_push(push), .cmd(push_cmd), .cmd_full(full)
  );

  lz4d_queue u_queue (
    .clk, .rst_n, .push, .din(push_cmd), .full, .not_empty(avail), .pop, .dout(pop_cmd)
  );

  lz4d_back u_back (
    .clk, .rst_n, .cmd_avail(avail), .cmd(pop_cmd), .cmd_pop(pop),
    .out_valid, .out_stall, .out_item
  );

endmodule
